### src/hht_pkg.sv
// Shared types, constants and helpers for the IPv4 fragment hole tracker.
package hht_pkg;

   localparam int HhtCells = 16;
   localparam logic [15:0] HhtLastPayloadByte = 16'd65515;
   localparam logic [15:0] HhtLenMax = 16'hFFFF;

   localparam logic [2:0] StatPending  = 3'd0;
   localparam logic [2:0] StatComplete = 3'd1;
   localparam logic [2:0] StatInvalid  = 3'd2;
   localparam logic [2:0] StatTimeout  = 3'd3;
   localparam logic [2:0] StatOverflow = 3'd4;

   // fragment word broadcast to every cell; init reaches cell 0 only
   typedef struct packed {
      logic [15:0] first;
      logic [16:0] last;
      logic        mf;
      logic        clear;
      logic        init;
   } hht_op_type;

   // token handed from cell to cell, with a split-off hole waiting for a slot
   typedef struct packed {
      logic        valid;
      logic        lap2;
      logic        pend;
      logic [15:0] pstart;
      logic [15:0] pend_end;
   } hht_tok_type;

   function automatic logic [15:0] sat_len(input logic [5:0] hdr, input logic [16:0] pe);
      logic [17:0] sum;
      sum = {12'd0, hdr} + {1'b0, pe};
      return (sum > {2'b00, HhtLenMax}) ? HhtLenMax : sum[15:0];
   endfunction

endpackage

### src/hht_cell.sv
// One hole-table cell: holds one hole and processes the token passing through.
module hht_cell import hht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  hht_op_type  op,
   input  hht_tok_type tok_in,
   output hht_tok_type tok_out,
   output logic        hole_valid
);

   logic        valid_ff, valid_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] end_ff, end_in;
   hht_tok_type tok_ff, tok_in_n;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      tok_in_n = tok_in;
      if (tok_in.valid && !tok_in.lap2 && valid_ff) begin
         if (!(end_ff < op.first || op.last < {1'b0, start_ff})) begin
            valid_in = 1'b0;
            if (start_ff < op.first) begin
               end_in   = op.first - 16'd1;
               valid_in = 1'b1;
            end
            if (op.last < {1'b0, end_ff} && op.mf) begin
               if (valid_in) begin
                  tok_in_n.pend     = 1'b1;
                  tok_in_n.pstart   = op.last[15:0] + 16'd1;
                  tok_in_n.pend_end = end_ff;
               end else begin
                  valid_in = 1'b1;
                  start_in = op.last[15:0] + 16'd1;
               end
            end
         end
         if (!op.mf && valid_in && {1'b0, start_in} > op.last) begin
            valid_in = 1'b0;
         end
      end
      if (tok_in.valid && tok_in_n.pend && !valid_in) begin
         valid_in      = 1'b1;
         start_in      = tok_in_n.pstart;
         end_in        = tok_in_n.pend_end;
         tok_in_n.pend = 1'b0;
      end
      if (op.clear) begin
         valid_in = 1'b0;
      end
      if (op.init) begin
         valid_in = 1'b1;
         start_in = 16'd0;
         end_in   = HhtLastPayloadByte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_n;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign tok_out    = tok_ff;
   assign hole_valid = valid_ff;

endmodule

### src/ipv4_fragment_hole_tracker_unit.sv
// Top level of the IPv4 fragment hole tracker: session control and the chain of hole cells.
// An accepted fragment word starts a token that walks the 16-cell chain through each hole cell's
// token register; the result is then formed and loaded into the output register.
// When a fragment splits a hole and no free cell follows that hole in the chain, the token goes
// round a second time. A timer tick that times the session out gives a result through the same
// output register; any other tick gives none and leaves the input ready. One word is worked on
// at a time; a new word is taken on the cycle after the previous result is loaded, and a
// stalled result holds the input off until the output register frees up.
module ipv4_fragment_hole_tracker_unit import hht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_frag_offset,
   input  logic [15:0] req_frag_total_len,
   input  logic [5:0]  req_frag_header_len,
   input  logic        req_more_fragments,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_datagram_length,
   output logic        rsp_send_time_exceeded,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StPush = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        session_ff, session_in;
   logic        first_seen_ff, first_seen_in;
   logic [5:0]  hdr_ff, hdr_in;
   logic [16:0] pe_ff, pe_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] timeout_ff;
   logic [15:0] first_ff, first_in;
   logic [16:0] last_ff, last_in;
   logic        mf_ff, mf_in;
   logic        start_tok_ff, start_tok_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [15:0] res_len_ff, res_len_in;
   logic        res_te_ff, res_te_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [15:0] rsp_len_ff;
   logic        rsp_te_ff;

   logic        cell_clear, cell_init;
   hht_tok_type tok_chain [0:HhtCells];
   logic [HhtCells-1:0] valid_vec;
   hht_tok_type tok_last;

   logic        accept;
   logic [15:0] len;
   logic [16:0] last_v, end_v;
   logic        bad;
   logic        fs_cur;
   logic [16:0] pe_cur;
   logic [15:0] el_next, limit;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == StIdle);
   assign tok_last  = tok_chain[HhtCells];

   always_comb begin
      tok_chain[0] = '0;
      if (start_tok_ff) begin
         tok_chain[0].valid = 1'b1;
      end else if (tok_last.valid && tok_last.pend && !tok_last.lap2) begin
         tok_chain[0]      = tok_last;
         tok_chain[0].lap2 = 1'b1;
      end
   end

   genvar g;
   generate
      for (g = 0; g < HhtCells; g++) begin : g_cell
         hht_op_type op_g;
         always_comb begin
            op_g.first = first_ff;
            op_g.last  = last_ff;
            op_g.mf    = mf_ff;
            op_g.clear = cell_clear;
            op_g.init  = (g == 0) ? cell_init : 1'b0;
         end
         hht_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op_g),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .hole_valid (valid_vec[g])
         );
      end
   endgenerate

   always_comb begin
      len     = req_frag_total_len - {10'd0, req_frag_header_len};
      last_v  = {1'b0, req_frag_offset} + {1'b0, len} - 17'd1;
      end_v   = last_v + 17'd1;
      bad     = (req_frag_total_len <= {10'd0, req_frag_header_len}) ||
                (req_more_fragments && (len[2:0] != 3'd0));
      fs_cur  = session_ff ? first_seen_ff : 1'b0;
      pe_cur  = session_ff ? pe_ff : 17'd0;
      el_next = (elapsed_ff < 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
      limit   = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   end

   always_comb begin
      state_in      = state_ff;
      session_in    = session_ff;
      first_seen_in = first_seen_ff;
      hdr_in        = hdr_ff;
      pe_in         = pe_ff;
      elapsed_in    = elapsed_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      mf_in         = mf_ff;
      start_tok_in  = 1'b0;
      res_status_in = res_status_ff;
      res_len_in    = res_len_ff;
      res_te_in     = res_te_ff;
      cell_clear    = 1'b0;
      cell_init     = 1'b0;
      case (state_ff)
         StIdle: begin
            if (accept && !req_type) begin
               if (!session_ff) begin
                  session_in    = 1'b1;
                  first_seen_in = 1'b0;
                  hdr_in        = req_frag_header_len;
                  pe_in         = 17'd0;
                  elapsed_in    = 16'd0;
                  cell_clear    = 1'b1;
                  cell_init     = 1'b1;
               end
               if (bad) begin
                  session_in    = 1'b0;
                  cell_clear    = 1'b1;
                  cell_init     = 1'b0;
                  res_status_in = StatInvalid;
                  res_len_in    = 16'd0;
                  res_te_in     = 1'b0;
                  state_in      = StPush;
               end else begin
                  if (req_frag_offset == 16'd0 && !fs_cur &&
                      ({10'd0, req_frag_header_len} + 16'd8 <= req_frag_total_len)) begin
                     first_seen_in = 1'b1;
                     hdr_in        = req_frag_header_len;
                  end
                  pe_in        = (end_v > pe_cur) ? end_v : pe_cur;
                  first_in     = req_frag_offset;
                  last_in      = last_v;
                  mf_in        = req_more_fragments;
                  start_tok_in = 1'b1;
                  state_in     = StRun;
               end
            end else if (accept && req_type && session_ff) begin
               elapsed_in = el_next;
               if (el_next >= limit) begin
                  session_in    = 1'b0;
                  cell_clear    = 1'b1;
                  res_status_in = StatTimeout;
                  res_len_in    = sat_len(hdr_ff, pe_ff);
                  res_te_in     = first_seen_ff;
                  state_in      = StPush;
               end
            end
         end
         StRun: begin
            if (tok_last.valid && tok_last.pend && tok_last.lap2) begin
               session_in    = 1'b0;
               cell_clear    = 1'b1;
               res_status_in = StatOverflow;
               res_len_in    = 16'd0;
               res_te_in     = 1'b0;
               state_in      = StPush;
            end else if (tok_last.valid && !tok_last.pend) begin
               res_len_in = sat_len(hdr_ff, pe_ff);
               res_te_in  = 1'b0;
               if (|valid_vec) begin
                  res_status_in = StatPending;
               end else begin
                  res_status_in = StatComplete;
                  session_in    = 1'b0;
               end
               state_in = StPush;
            end
         end
         StPush: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == StPush && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         session_ff    <= 1'b0;
         first_seen_ff <= 1'b0;
         hdr_ff        <= 6'd20;
         pe_ff         <= 17'd0;
         elapsed_ff    <= 16'd0;
         timeout_ff    <= 16'd60;
         start_tok_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         session_ff    <= session_in;
         first_seen_ff <= first_seen_in;
         hdr_ff        <= hdr_in;
         pe_ff         <= pe_in;
         elapsed_ff    <= elapsed_in;
         start_tok_ff  <= start_tok_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
      first_ff      <= first_in;
      last_ff       <= last_in;
      mf_ff         <= mf_in;
      res_status_ff <= res_status_in;
      res_len_ff    <= res_len_in;
      res_te_ff     <= res_te_in;
      if (state_ff == StPush && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= res_status_ff;
         rsp_len_ff    <= res_len_ff;
         rsp_te_ff     <= res_te_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_datagram_length    = rsp_len_ff;
   assign rsp_send_time_exceeded = rsp_te_ff;

endmodule

### src/hht_checker.sv
// Port-level checker for the IPv4 fragment hole tracker, bound to the top level.
module hht_checker import hht_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_datagram_length,
   input logic        rsp_send_time_exceeded
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= StatOverflow))
      else $error("result status out of range");

   a_abort_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == StatInvalid || rsp_status == StatOverflow)
      |-> (rsp_datagram_length == 16'd0))
      else $error("aborted session reports a length");

   a_te_only_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_time_exceeded |-> (rsp_status == StatTimeout))
      else $error("time exceeded flag without timeout");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result word dropped while stalled");

endmodule

bind ipv4_fragment_hole_tracker_unit hht_checker u_hht_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_status             (rsp_status),
   .rsp_datagram_length    (rsp_datagram_length),
   .rsp_send_time_exceeded (rsp_send_time_exceeded)
);

### verif/ipv4_fragment_hole_tracker_unit_test.sv
// Testbench for the IPv4 fragment hole tracker: directed and random fragment/tick words.
`timescale 1ns / 100ps

module ipv4_fragment_hole_tracker_unit_test;
   import hht_pkg::*;

   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] dlen;
      logic        tx;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [15:0] req_frag_offset = '0;
   logic [15:0] req_frag_total_len = '0;
   logic [5:0]  req_frag_header_len = 6'd20;
   logic        req_more_fragments = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_datagram_length;
   logic        rsp_send_time_exceeded;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // tracker shadow state
   logic [15:0] trk_timeout;
   logic        trk_active;
   logic [15:0] trk_hs [HhtCells];
   logic [15:0] trk_he [HhtCells];
   logic        trk_hv [HhtCells];
   logic        trk_first_seen;
   logic [5:0]  trk_hdr;
   logic [16:0] trk_pend;
   logic [15:0] trk_elapsed;

   rsp_word_type expected_rsps[$];
   int errors = 0;
   int words_sent = 0;
   int rsps_seen = 0;
   int n_complete = 0;
   int n_timeout = 0;
   int n_overflow = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   ipv4_fragment_hole_tracker_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_frag_offset(req_frag_offset), .req_frag_total_len(req_frag_total_len),
      .req_frag_header_len(req_frag_header_len), .req_more_fragments(req_more_fragments),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_datagram_length(rsp_datagram_length),
      .rsp_send_time_exceeded(rsp_send_time_exceeded),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [15:0] track_len();
      logic [17:0] sum;
      sum = {12'd0, trk_hdr} + {1'b0, trk_pend};
      return (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic void track_reset();
      trk_timeout = 16'd60;
      trk_active = 1'b0;
      trk_first_seen = 1'b0;
      trk_hdr = 6'd20;
      trk_pend = '0;
      trk_elapsed = '0;
      for (int i = 0; i < HhtCells; i++) begin
         trk_hv[i] = 1'b0;
         trk_hs[i] = '0;
         trk_he[i] = '0;
      end
   endfunction

   function automatic void track_close();
      trk_active = 1'b0;
      for (int i = 0; i < HhtCells; i++) trk_hv[i] = 1'b0;
   endfunction

   function automatic void track_push(logic [2:0] st, logic [15:0] len, logic tx);
      rsp_word_type r;
      r.status = st;
      r.dlen = len;
      r.tx = tx;
      expected_rsps.push_back(r);
   endfunction

   function automatic void track_word(logic typ, logic [15:0] off, logic [15:0] tot,
                                      logic [5:0] hdr, logic mf);
      logic [31:0] first, len, last, fend, limit, hs, he;
      int s;
      bit any;
      if (typ) begin
         if (!trk_active) return;
         if (trk_elapsed < 16'hFFFF) trk_elapsed++;
         limit = (trk_timeout == 16'd0) ? 32'd1 : 32'(trk_timeout);
         if (32'(trk_elapsed) < limit) return;
         track_push(StatTimeout, track_len(), trk_first_seen);
         track_close();
         return;
      end
      if (!trk_active) begin
         track_close();
         trk_active = 1'b1;
         trk_hs[0] = 16'd0;
         trk_he[0] = HhtLastPayloadByte;
         trk_hv[0] = 1'b1;
         trk_first_seen = 1'b0;
         trk_hdr = hdr;
         trk_pend = '0;
         trk_elapsed = '0;
      end
      if (tot <= hdr || (mf && (((tot - hdr) & 7) != 0))) begin
         track_close();
         track_push(StatInvalid, 16'd0, 1'b0);
         return;
      end
      first = 32'(off);
      len = 32'(tot) - 32'(hdr);
      last = first + len - 32'd1;
      fend = first + len;
      if (first == 0 && hdr + 8 <= tot && !trk_first_seen) begin
         trk_first_seen = 1'b1;
         trk_hdr = hdr;
      end
      if (fend > 32'(trk_pend)) trk_pend = fend[16:0];
      for (int i = 0; i < HhtCells; i++) begin
         if (!trk_hv[i]) continue;
         hs = 32'(trk_hs[i]);
         he = 32'(trk_he[i]);
         if (he < first || last < hs) continue;
         trk_hv[i] = 1'b0;
         if (hs < first) begin
            trk_he[i] = 16'(first - 32'd1);
            trk_hv[i] = 1'b1;
         end
         if (last < he && mf) begin
            s = -1;
            if (trk_hv[i]) begin
               for (int j = 0; j < HhtCells; j++)
                  if (!trk_hv[j] && s < 0) s = j;
            end else s = i;
            if (s < 0) begin
               track_close();
               track_push(StatOverflow, 16'd0, 1'b0);
               return;
            end
            trk_hs[s] = 16'(last + 32'd1);
            trk_he[s] = 16'(he);
            trk_hv[s] = 1'b1;
         end
      end
      if (!mf)
         for (int i = 0; i < HhtCells; i++)
            if (trk_hv[i] && 32'(trk_hs[i]) > last) trk_hv[i] = 1'b0;
      any = 0;
      for (int i = 0; i < HhtCells; i++) any |= trk_hv[i];
      if (any) track_push(StatPending, track_len(), 1'b0);
      else begin
         track_push(StatComplete, track_len(), 1'b0);
         track_close();
      end
   endfunction

   // receiver: random stall, check each accepted word
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result word status=%0d", rsp_status);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status == StatComplete) n_complete++;
               if (rsp_status == StatTimeout) n_timeout++;
               if (rsp_status == StatOverflow) n_overflow++;
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_datagram_length !== e.dlen) begin
                  $error("datagram_length: expected %0d actual %0d", e.dlen,
                         rsp_datagram_length);
                  errors++;
               end
               if (rsp_send_time_exceeded !== e.tx) begin
                  $error("send_time_exceeded: expected %0d actual %0d", e.tx,
                         rsp_send_time_exceeded);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid stays up after the accepting edge; the next send or drain drops or reuses it
   task automatic send_word(logic typ, logic [15:0] off, logic [15:0] tot,
                            logic [5:0] hdr, logic mf);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_frag_offset <= off;
      req_frag_total_len <= tot;
      req_frag_header_len <= hdr;
      req_more_fragments <= mf;
      track_word(typ, off, tot, hdr, mf);
      words_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frag(logic [15:0] off, int plen, logic [5:0] hdr, logic mf);
      send_word(1'b0, off, 16'(plen + hdr), hdr, mf);
   endtask

   task automatic send_tick();
      send_word(1'b1, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trk_timeout = v;
   endtask

   // a tick-driven end of any open session
   task automatic flush_session();
      while (trk_active) send_tick();
   endtask

   task automatic test_directed();
      send_tick();
      send_frag(16'd0, 16, 6'd20, 1'b1);
      send_frag(16'd16, 8, 6'd24, 1'b0);
      send_frag(16'd0, 0, 6'd20, 1'b0);
      send_word(1'b0, 16'd0, 16'd10, 6'd20, 1'b0);
      send_frag(16'd8, 5, 6'd20, 1'b1);
      send_frag(16'd65528, 7, 6'd63, 1'b0);
      send_frag(16'd0, 65515, 6'd20, 1'b0);
      send_word(1'b0, 16'd0, 16'hFFFF, 6'd0, 1'b0);
      send_frag(16'd8, 8, 6'd20, 1'b1);
      send_frag(16'd0, 8, 6'd60, 1'b1);
      send_frag(16'd0, 16, 6'd40, 1'b1);
      for (int i = 0; i < 17; i++) send_frag(16'(32 + 16 * i), 8, 6'd20, 1'b1);
      send_frag(16'd16, 8, 6'd20, 1'b1);
      flush_session();
   endtask

   task automatic test_timeout();
      write_timeout(16'd0);
      send_frag(16'd8, 8, 6'd20, 1'b1);
      send_tick();
      write_timeout(16'd3);
      send_frag(16'd0, 8, 6'd20, 1'b1);
      repeat (3) send_tick();
      write_timeout(16'hFFFF);
      send_frag(16'd0, 8, 6'd20, 1'b1);
      repeat (5) send_tick();
      send_frag(16'd0, 16, 6'd20, 1'b0);
      write_timeout(16'd60);
   endtask

   // well-formed datagram cut into shuffled 8-byte aligned pieces, with noise
   task automatic random_datagram();
      int units, pieces, pos, len;
      int starts[$];
      int lens[$];
      logic [5:0] hdr;
      units = $urandom_range(1, ($urandom_range(9) == 0) ? 8190 : 40);
      pieces = $urandom_range(1, 10);
      pos = 0;
      while (pos < units) begin
         len = $urandom_range(1, (units + pieces - 1) / pieces);
         if (pos + len > units) len = units - pos;
         starts.push_back(pos);
         lens.push_back(len);
         pos += len;
      end
      starts.shuffle();
      for (int i = 0; i < starts.size(); i++) begin
         lens[i] = 0;
         foreach (starts[k]) lens[i] = lens[i];
      end
      hdr = 6'($urandom_range(20, 60));
      foreach (starts[i]) begin
         int nxt, plen;
         bit mf;
         nxt = units;
         foreach (starts[k]) if (starts[k] > starts[i] && starts[k] < nxt) nxt = starts[k];
         plen = (nxt - starts[i]) * 8;
         mf = (nxt != units);
         if (!mf) plen = plen - $urandom_range(0, 7);
         if (plen + hdr > 65535) plen = 65535 - hdr;
         case ($urandom_range(19))
            0: send_tick();
            1: send_word(1'b0, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
            2: send_frag(16'($urandom_range(8191) * 8), $urandom_range(1, 400), hdr,
                         1'($urandom));
            default: ;
         endcase
         send_frag(16'(starts[i] * 8), plen, hdr, mf);
         if (!trk_active) break;
      end
      if ($urandom_range(3) == 0) flush_session();
   endtask

   task automatic test_random(int words);
      int target;
      target = words_sent + words;
      while (words_sent < target) begin
         if ($urandom_range(7) == 0)
            send_word(1'b0, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
         else random_datagram();
      end
      flush_session();
   endtask

   initial begin
      track_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_timeout();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(250);
      write_timeout(16'd1);
      send_idle_pct = 86; recv_stall_pct = 0;
      test_random(200);
      write_timeout(16'd25);
      send_idle_pct = 0; recv_stall_pct = 86;
      test_random(200);
      write_timeout(16'd60);
      send_idle_pct = 25; recv_stall_pct = 25;
      test_random(250);
      drain();
      $display("Sent %0d words, checked %0d results", words_sent, rsps_seen);
      $display("Completed %0d, timed out %0d, overflowed %0d", n_complete, n_timeout,
               n_overflow);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
src/hht_pkg.sv
src/hht_cell.sv
src/ipv4_fragment_hole_tracker_unit.sv
src/hht_checker.sv
verif/ipv4_fragment_hole_tracker_unit_test.sv
